FILE: design/twf_pkg.sv
// Shared types and constants for the tag weight fold unit.
// Used by the front end, the request queue, the fold engine and the top level.
package twf_pkg;

  localparam int TAG_BITS_DEF = 64;
  localparam int unsigned RESULT_CAP_DEF = 268435456;
  localparam logic [31:0] BLOCKED_CODE_DEF = 32'hFFFF_FFFF;

  localparam int WORD_W   = 64;
  localparam int INDEX_W  = 6;
  localparam int WEIGHT_W = 33;

  localparam logic [WEIGHT_W-1:0] ONE_Q16    = WEIGHT_W'(65536);
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = WEIGHT_W'(64'h1_0000_0000);

  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_FOLD = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // One classified request as it travels from the front end to the fold engine.
  typedef struct packed {
    logic                load;
    logic                blocked;
    logic [WORD_W-1:0]   word;
    logic [INDEX_W-1:0]  idx;
    logic [WEIGHT_W-1:0] mult_w;
    logic [WEIGHT_W-1:0] add_w;
  } twf_item_t;

endpackage

FILE: design/twf_front.sv
// Front end: classifies incoming requests, applies the masks and clamps weights.
// Depends on twf_pkg.
module twf_front #(
  parameter int TAG_BITS = twf_pkg::TAG_BITS_DEF
) (
  input  logic                           in_valid,
  input  logic                           q_full,
  input  logic                           cmd,
  input  logic [twf_pkg::WORD_W-1:0]     tag_word,
  input  logic [twf_pkg::INDEX_W-1:0]    tag_index,
  input  logic [twf_pkg::WEIGHT_W-1:0]   mult_weight,
  input  logic [twf_pkg::WEIGHT_W-1:0]   add_weight,
  input  logic [twf_pkg::WORD_W-1:0]     veto_mask,
  input  logic [twf_pkg::WORD_W-1:0]     need_mask,
  output logic                           in_stall,
  output logic                           q_push,
  output twf_pkg::twf_item_t             q_item
);
  import twf_pkg::*;

  localparam logic [WORD_W-1:0] FOLD_MASK =
    (TAG_BITS >= WORD_W) ? {WORD_W{1'b1}} : ((WORD_W'(1) << TAG_BITS) - WORD_W'(1));

  logic              idx_ok;
  logic              rejected;
  logic [WEIGHT_W-1:0] mult_c;

  always_comb begin
    idx_ok   = (7'(tag_index) < 7'(TAG_BITS));
    rejected = ((tag_word & veto_mask) != '0) ||
               ((need_mask != '0) && ((tag_word & need_mask) == '0));
    mult_c   = (mult_weight > WEIGHT_MAX) ? WEIGHT_MAX : mult_weight;

    q_item.load    = (cmd == CMD_LOAD);
    q_item.blocked = rejected;
    q_item.word    = tag_word & FOLD_MASK;
    q_item.idx     = tag_index;
    q_item.mult_w  = (mult_c == '0) ? ONE_Q16 : mult_c;
    q_item.add_w   = (add_weight > WEIGHT_MAX) ? WEIGHT_MAX : add_weight;
  end

  // A load aimed beyond the table is consumed without entering the queue.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && ((cmd == CMD_FOLD) || idx_ok);

endmodule

FILE: design/twf_queue.sv
// Short in-order queue between the front end and the fold engine.
// Depends on twf_pkg.
module twf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  twf_pkg::twf_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output twf_pkg::twf_item_t head
);
  import twf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  twf_item_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  assign full      = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

FILE: design/twf_back.sv
// Fold engine: weight tables, per-bit multiply-accumulate sequencer, output register.
// Depends on twf_pkg.
module twf_back #(
  parameter int          TAG_BITS     = twf_pkg::TAG_BITS_DEF,
  parameter int unsigned RESULT_CAP   = twf_pkg::RESULT_CAP_DEF,
  parameter logic [31:0] BLOCKED_CODE = twf_pkg::BLOCKED_CODE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  twf_pkg::twf_item_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               blocked,
  output logic [31:0]        mult_q,
  output logic [28:0]        add_q
);
  import twf_pkg::*;

  localparam int AW = (TAG_BITS > 1) ? $clog2(TAG_BITS) : 1;
  localparam logic [55:0] CAP_Q32   = 56'(RESULT_CAP) << 24;
  localparam logic [55:0] ONE_Q32   = 56'(1) << 32;
  localparam logic [55:0] PROD_INIT = (ONE_Q32 > CAP_Q32) ? CAP_Q32 : ONE_Q32;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MUL, S_ACC, S_FIN, S_OUT} state_t;

  state_t              state;
  logic [WEIGHT_W-1:0] mult_mem [TAG_BITS];
  logic [WEIGHT_W-1:0] add_mem  [TAG_BITS];
  logic [TAG_BITS-1:0] entry_valid;
  logic [WEIGHT_W-1:0] rd_mult;
  logic [WEIGHT_W-1:0] rd_add;
  logic                rd_valid;

  logic [WORD_W-1:0]   rem;
  logic [55:0]         prod;
  logic [38:0]         sum;
  logic [56:0]         hw;
  logic [64:0]         lw;
  logic                res_blocked;
  logic [31:0]         res_mult;
  logic [28:0]         res_add;

  logic [WORD_W-1:0]   low_bit;
  logic [AW-1:0]       scan_addr;
  logic                mem_we;
  logic [AW-1:0]       wr_addr;
  logic [WEIGHT_W-1:0] w_mult;
  logic [WEIGHT_W-1:0] w_add;
  logic [56:0]         prod_sum;
  logic [55:0]         prod_sat;
  logic [56:0]         mq_round;
  logic [32:0]         mq_c;
  logic [39:0]         aq_round;
  logic [31:0]         aq_c;
  logic                out_load;

  always_comb begin
    low_bit   = rem & (~rem + WORD_W'(1));
    scan_addr = '0;
    for (int b = 0; b < TAG_BITS; b++) begin
      if (low_bit[b]) scan_addr = scan_addr | AW'(b);
    end
    wr_addr = q_head.idx[AW-1:0];
    mem_we  = (state == S_IDLE) && q_not_empty && q_head.load;
    q_pop   = (state == S_IDLE) && q_not_empty;

    w_mult = rd_valid ? rd_mult : ONE_Q16;
    w_add  = rd_valid ? rd_add  : '0;

    prod_sum = {1'b0, hw[39:0], 16'b0} + 57'((lw + 65'(32768)) >> 16);
    if (hw > 57'(CAP_Q32 >> 16)) prod_sat = CAP_Q32;
    else if (prod_sum > 57'(CAP_Q32)) prod_sat = CAP_Q32;
    else prod_sat = prod_sum[55:0];

    mq_round = 57'(prod) + 57'(1 << 23);
    mq_c     = (mq_round[56:24] > 33'(RESULT_CAP)) ? 33'(RESULT_CAP) : mq_round[56:24];
    aq_round = 40'(sum) + 40'(128);
    aq_c     = (aq_round[39:8] > 32'(RESULT_CAP)) ? 32'(RESULT_CAP) : aq_round[39:8];

    // The output register takes a new result when it is empty or being drained.
    out_load = (state == S_OUT) && (!out_valid || !out_stall);
  end

  // Table storage: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mult_mem[wr_addr] <= q_head.mult_w;
      add_mem[wr_addr]  <= q_head.add_w;
    end
    rd_mult <= mult_mem[scan_addr];
    rd_add  <= add_mem[scan_addr];
  end

  // Entries never loaded since reset read as neutral weights.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (mem_we) entry_valid[wr_addr] <= 1'b1;
      rd_valid <= entry_valid[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_not_empty && !q_head.load) begin
            if (q_head.blocked) begin
              res_blocked <= 1'b1;
              res_mult    <= BLOCKED_CODE;
              res_add     <= '0;
              state       <= S_OUT;
            end else begin
              res_blocked <= 1'b0;
              rem         <= q_head.word;
              prod        <= PROD_INIT;
              sum         <= '0;
              state       <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rem == '0) begin
            state <= S_FIN;
          end else begin
            rem   <= rem & ~low_bit;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          hw    <= 57'(prod[55:32]) * 57'(w_mult);
          lw    <= 65'(prod[31:0]) * 65'(w_mult);
          sum   <= sum + 39'(w_add);
          state <= S_ACC;
        end
        S_ACC: begin
          prod  <= prod_sat;
          state <= S_SCAN;
        end
        S_FIN: begin
          res_mult <= mq_c[31:0];
          res_add  <= aq_c[28:0];
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            blocked   <= res_blocked;
            mult_q    <= res_mult;
            add_q     <= res_add;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/tag_weight_fold_unit.sv
// Top level of the tag weight fold unit: configuration registers and module wiring.
// Depends on twf_pkg, twf_front, twf_queue and twf_back.
//
// Usage: the input channel (in_valid / in_stall) carries one request per
// handshake. A load request (cmd = 1) writes one entry of the multiplier
// and adder tables and yields no result. A fold request (cmd = 0) yields
// exactly one result on the output channel (out_valid / out_stall):
// blocked, mult_q and add_q, in request order.
// Sequence: a blocked word passes from the queue through S_OUT into the
// output register; an accepted word passes S_SCAN, then per set tag bit
// one table read, one multiply and one saturate step (S_SCAN, S_MUL, S_ACC), then
// S_FIN and S_OUT. The fold engine takes a load without leaving S_IDLE,
// so loads alone stream at one request per cycle. A
// two-entry queue lets new requests enter while the engine is busy, and the
// output register holds a finished result while the next one is folded.
// When the receiver stalls, the result stays on the outputs; the engine
// waits, then the queue fills and in_stall rises. Reset clears the masks,
// the queue and the output; every table entry then reads as 1.0 and 0.0.
// The user must write the masks through cfg_write/cfg_index/cfg_data only while idle; the block does not enforce it.
module tag_weight_fold_unit #(
  parameter int          TAG_BITS     = twf_pkg::TAG_BITS_DEF,
  parameter int unsigned RESULT_CAP   = twf_pkg::RESULT_CAP_DEF,
  parameter logic [31:0] BLOCKED_CODE = twf_pkg::BLOCKED_CODE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [63:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [63:0]                  tag_word,
  input  logic [5:0]                   tag_index,
  input  logic [32:0]                  mult_weight,
  input  logic [32:0]                  add_weight,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         blocked,
  output logic [31:0]                  mult_q,
  output logic [28:0]                  add_q
);
  import twf_pkg::*;

  localparam logic REG_VETO_MASK = 1'b0;
  localparam logic REG_NEED_MASK = 1'b1;

  logic [63:0] veto_mask;
  logic [63:0] need_mask;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_not_empty;
  twf_item_t   q_in;
  twf_item_t   q_head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      veto_mask <= '0;
      need_mask <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VETO_MASK: veto_mask <= cfg_data;
        REG_NEED_MASK: need_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  twf_front #(.TAG_BITS(TAG_BITS)) u_front (
    .in_valid     (in_valid),
    .q_full       (q_full),
    .cmd          (cmd),
    .tag_word     (tag_word),
    .tag_index    (tag_index),
    .mult_weight  (mult_weight),
    .add_weight   (add_weight),
    .veto_mask    (veto_mask),
    .need_mask    (need_mask),
    .in_stall     (in_stall),
    .q_push       (q_push),
    .q_item       (q_in)
  );

  twf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  twf_back #(
    .TAG_BITS     (TAG_BITS),
    .RESULT_CAP   (RESULT_CAP),
    .BLOCKED_CODE (BLOCKED_CODE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .blocked     (blocked),
    .mult_q      (mult_q),
    .add_q       (add_q)
  );

`ifndef SYNTH
  // A rejected word always carries the sentinel and a zero adder.
  a_blocked_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && blocked |-> (mult_q == BLOCKED_CODE) && (add_q == '0))
    else $error("blocked result without sentinel");

  // Folded multiplier results never exceed the cap.
  a_result_capped: assert property (@(posedge clk) disable iff (rst)
    out_valid && !blocked |-> (33'(mult_q) <= 33'(RESULT_CAP)))
    else $error("folded multiplier above cap");

  // Nothing is presented in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented right after reset");
`endif

endmodule

FILE: dv/tb_tag_weight_fold_unit.sv
// Self-checking testbench for the tag weight fold unit: weight loads, mask tests and folding.
// Depends on twf_pkg and tag_weight_fold_unit; predicts each fold result and compares it.
`timescale 1ns / 100ps

module tb_tag_weight_fold_unit;
  import twf_pkg::*;

  localparam int unsigned CAP = 268435456;
  localparam logic [63:0] CAP_Q32 = 64'(CAP) << 24;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic CFG_BLOCK = 1'b0;
  localparam logic CFG_REQUIRE = 1'b1;

  typedef struct packed {
    logic        blocked;
    logic [31:0] mult_q;
    logic [28:0] add_q;
  } fold_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = CMD_FOLD;
  logic [63:0] tag_word = '0;
  logic [5:0]  tag_index = '0;
  logic [32:0] mult_weight = '0;
  logic [32:0] add_weight = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        blocked;
  logic [31:0] mult_q;
  logic [28:0] add_q;

  tag_weight_fold_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .tag_word(tag_word), .tag_index(tag_index),
    .mult_weight(mult_weight), .add_weight(add_weight),
    .out_valid(out_valid), .out_stall(out_stall),
    .blocked(blocked), .mult_q(mult_q), .add_q(add_q)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the block's state, kept by the predictor.
  logic [63:0] shadow_block;
  logic [63:0] shadow_require;
  logic [32:0] shadow_mult [64];
  logic [32:0] shadow_add [64];

  fold_result_t pending_folds[$];
  int  mismatches = 0;
  int  folds_checked = 0;
  int  loads_sent = 0;
  int  idle_cycles = 0;
  bit  timed_out = 1'b0;
  bit  quiet_mode = 1'b0;   // last part of the run: no idling on either side
  int  send_gap = 0;

  function automatic logic [32:0] clamp_weight(logic [32:0] w);
    return (w > 33'h1_0000_0000) ? 33'h1_0000_0000 : w;
  endfunction

  // Q.32 running product times a Q17.16 weight, rounded half up, saturated at the cap.
  function automatic logic [63:0] scale_product(logic [63:0] p, logic [32:0] w);
    logic [127:0] hw;
    logic [127:0] r;
    hw = 128'(p[63:32]) * 128'(w);
    if (hw > 128'(CAP_Q32 >> 16)) return CAP_Q32;
    r = (hw << 16) + ((128'(p[31:0]) * 128'(w) + 128'(1 << 15)) >> 16);
    return (r > 128'(CAP_Q32)) ? CAP_Q32 : r[63:0];
  endfunction

  // Applies one request to the shadow state; returns 1 with the result for a fold.
  function automatic bit predict_request(logic c, logic [63:0] word, logic [5:0] idx,
                                         logic [32:0] mw, logic [32:0] aw,
                                         output fold_result_t res);
    logic [63:0] p;
    logic [71:0] s;
    logic [71:0] mq;
    logic [71:0] aq;
    logic [32:0] m;
    res = '0;
    if (c == CMD_LOAD) begin
      m = clamp_weight(mw);
      shadow_mult[idx] = (m == 0) ? ONE_Q16 : m;
      shadow_add[idx] = clamp_weight(aw);
      return 1'b0;
    end
    if ((word & shadow_block) != 0 || (shadow_require != 0 && (word & shadow_require) == 0)) begin
      res.blocked = 1'b1;
      res.mult_q = BLOCKED_CODE_DEF;
      res.add_q = '0;
      return 1'b1;
    end
    p = 64'h1_0000_0000;
    s = '0;
    for (int b = 0; b < 64; b++) begin
      if (word[b]) begin
        p = scale_product(p, shadow_mult[b]);
        s += 72'(shadow_add[b]);
      end
    end
    mq = (72'(p) + 72'(1 << 23)) >> 24;
    aq = (s + 72'd128) >> 8;
    res.mult_q = (mq > 72'(CAP)) ? 32'(CAP) : mq[31:0];
    res.add_q = (aq > 72'(CAP)) ? 29'(CAP) : aq[28:0];
    return 1'b1;
  endfunction

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // Sends one request, with an optional random gap before it, and predicts its outcome.
  // The request stays valid after acceptance until the next one or an idle period replaces it.
  task automatic send_request(logic c, logic [63:0] word, logic [5:0] idx,
                              logic [32:0] mw, logic [32:0] aw);
    fold_result_t res;
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      wait_cycles($urandom_range(1, 13));
    end
    in_valid <= 1'b1;
    cmd <= c;
    tag_word <= word;
    tag_index <= idx;
    mult_weight <= mw;
    add_weight <= aw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_request(c, word, idx, mw, aw, res)) pending_folds.push_back(res);
    else loads_sent++;
  endtask

  task automatic fold(logic [63:0] word);
    send_request(CMD_FOLD, word, 6'($urandom), 33'({$urandom, $urandom}),
                 33'({$urandom, $urandom}));
  endtask

  task automatic load(logic [5:0] idx, logic [32:0] mw, logic [32:0] aw);
    send_request(CMD_LOAD, {$urandom, $urandom}, idx, mw, aw);
  endtask

  // Waits until every fold result is back, then lets a full fold latency pass.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_folds.size() != 0 && !timed_out) @(posedge clk);
    wait_cycles(220);
  endtask

  task automatic write_mask(logic which, logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (which == CFG_BLOCK) shadow_block = value;
    else shadow_require = value;
  endtask

  function automatic logic [32:0] random_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 33'h1_0000_0000;
      2: return 33'h1_FFFF_FFFF;
      3: return 33'(ONE_Q16);
      4: return 33'($urandom_range(0, 131072));
      5: return 33'($urandom_range(32768, 98304));
      default: return 33'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [63:0] sparse_word();
    logic [63:0] w;
    w = '0;
    repeat ($urandom_range(0, 6)) w[$urandom_range(0, 63)] = 1'b1;
    return w;
  endfunction

  // Directed: weight extremes, empty and full words, saturation and mask cases.
  task automatic test_directed;
    fold(64'h0);
    fold(64'hFFFF_FFFF_FFFF_FFFF);
    load(6'd0, 33'h1_FFFF_FFFF, 33'h1_FFFF_FFFF);
    load(6'd63, 33'h0, 33'h1_0000_0000);
    load(6'd1, 33'h1_0000_0000, 33'h0);
    load(6'd2, 33'h0_0000_0001, 33'h0_0000_0080);
    fold(64'h1);
    fold(64'h8000_0000_0000_0000);
    fold(64'h7);
    fold(64'h3);
    fold(64'hFFFF_FFFF_FFFF_FFFF);
    load(6'd5, 33'h0_0000_8000, 33'h0_0000_7F);
    fold(64'h23);
    fold(64'h20);
    drain();
    write_mask(CFG_BLOCK, 64'h8000_0000_0000_0001);
    write_mask(CFG_REQUIRE, 64'h0000_0000_0000_00F0);
    fold(64'h1);
    fold(64'h10);
    fold(64'h100);
    fold(64'h0);
    drain();
    write_mask(CFG_BLOCK, 64'hFFFF_FFFF_FFFF_FFFF);
    write_mask(CFG_REQUIRE, 64'hFFFF_FFFF_FFFF_FFFF);
    fold(64'h0);
    fold(64'h2);
    drain();
    write_mask(CFG_BLOCK, 64'h0);
    write_mask(CFG_REQUIRE, 64'h0);
  endtask

  // Random loads and folds; most words are sparse to keep fold latency short.
  task automatic test_random(int count, bit quiet_tail);
    logic [63:0] w;
    for (int i = 0; i < count; i++) begin
      if (quiet_tail && i == count - count / 5) quiet_mode = 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        load(6'($urandom), random_weight(), random_weight());
      end else begin
        case ($urandom_range(0, 9))
          0: w = {$urandom, $urandom};
          1: w = 64'hFFFF_FFFF_FFFF_FFFF;
          default: w = sparse_word();
        endcase
        fold(w);
      end
    end
  endtask

  task automatic test_random_masks;
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      write_mask(CFG_BLOCK, {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
      write_mask(CFG_REQUIRE, (phase[0]) ? 64'h0 : {$urandom, $urandom});
      test_random(140, phase == 3);
    end
  endtask

  // Receiver side: random stall bursts, checking every accepted result in order.
  always @(posedge clk) begin
    fold_result_t exp_res;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        folds_checked++;
        if (pending_folds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result blocked=%0d mult_q=%0h add_q=%0h",
                     blocked, mult_q, add_q);
        end else begin
          exp_res = pending_folds.pop_front();
          if (blocked !== exp_res.blocked || mult_q !== exp_res.mult_q ||
              add_q !== exp_res.add_q) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0h/%0h, got %0d/%0h/%0h",
                       exp_res.blocked, exp_res.mult_q, exp_res.add_q,
                       blocked, mult_q, add_q);
          end
        end
      end
      // Stall bursts of random length, none in the quiet part.
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
        $display("watchdog expired with %0d results outstanding", pending_folds.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    shadow_block = '0;
    shadow_require = '0;
    for (int i = 0; i < 64; i++) begin
      shadow_mult[i] = ONE_Q16;
      shadow_add[i] = '0;
    end
    wait_cycles(11);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_masks();
    drain();
    $display("covered %0d folds and %0d loads over several mask settings",
             folds_checked, loads_sent);
    if (mismatches == 0 && pending_folds.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_folds.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
